/* hw/rtl/sgf_pkg.sv */
// Shared types, widths and coefficient mapping for the symmetric smoothing FIR.
// No dependencies.
`default_nettype none

package sgf_pkg;

	localparam int TAPS       = 15;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int NUM_OUTER  = 7;
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int CFG_IDX_W  = REG_IDX_W + 1;
	localparam int ACC_W      = SAMPLE_W + COEF_W + $clog2(TAPS) + 1;
	localparam int FRAC_SHIFT = 16;
	localparam int RND_W      = ACC_W - FRAC_SHIFT;

	localparam logic [REG_IDX_W-1:0] CENTER_REG = REG_IDX_W'(NUM_REGS - 1);
	localparam logic [COEF_W-1:0]    COEF_OUTER_RST  = '0;
	localparam logic [COEF_W-1:0]    COEF_CENTER_RST = '1;

	localparam logic signed [ACC_W-1:0]    ROUND_HALF = ACC_W'(1 << (FRAC_SHIFT - 1));
	localparam logic signed [RND_W-1:0]    RND_MAX    = RND_W'(32767);
	localparam logic signed [RND_W-1:0]    RND_MIN    = -RND_W'(32768);
	localparam logic signed [SAMPLE_W-1:0] SAT_MAX    = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAT_MIN    = 16'sh8000;

	typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_arr_t;

	// one wavefront moving down the cell row
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic signed [ACC_W-1:0]    sum;
	} wave_t;

	// mirrored coefficient for a tap; center register for the middle tap of odd TAPS
	function automatic logic [COEF_W-1:0] tap_coef(input int tap, input coef_arr_t c);
		int mirror;
		int k;
		mirror = TAPS - 1 - tap;
		k = (tap < mirror) ? tap : mirror;
		if ((TAPS % 2) == 1 && tap == (TAPS - 1) / 2)
			return c[CENTER_REG];
		if (k < NUM_OUTER)
			return c[REG_IDX_W'(k)];
		return '0;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sgf_cell.sv */
// One tap cell: holds a delay-line sample, swaps in the sample carried by the
// passing wavefront and adds its product to the running sum. Uses sgf_pkg.
`default_nettype none

module sgf_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [sgf_pkg::COEF_W-1:0]  coef,
	input  wire sgf_pkg::wave_t              wave_i,
	output sgf_pkg::wave_t                   wave_o
);
	import sgf_pkg::*;

	logic signed [SAMPLE_W-1:0]       tap_q;
	logic                             valid_s1;
	logic signed [SAMPLE_W-1:0]       sample_s1;
	logic signed [ACC_W-1:0]          sum_s1;
	logic signed [SAMPLE_W+COEF_W:0]  prod;

	assign prod = wave_i.sample * $signed({1'b0, coef});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= wave_i.valid;
			if (wave_i.valid) begin
				tap_q <= wave_i.sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && wave_i.valid) begin
			sample_s1 <= tap_q;
			sum_s1    <= wave_i.sum + ACC_W'(prod);
		end
	end

	assign wave_o.valid  = valid_s1;
	assign wave_o.sample = sample_s1;
	assign wave_o.sum    = sum_s1;

endmodule

`default_nettype wire

/* hw/rtl/sgf_out.sv */
// Output stage: rounds the Q21.16 sum to an integer, saturates to Q16.0 and holds
// the result beat. Uses sgf_pkg.
`default_nettype none

module sgf_out (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire sgf_pkg::wave_t                    wave_i,
	output logic                                   valid,
	output logic signed [sgf_pkg::SAMPLE_W-1:0]    smoothed,
	output logic                                   clipped
);
	import sgf_pkg::*;

	logic signed [ACC_W-1:0]    biased;
	logic signed [RND_W-1:0]    rnd;
	logic signed [SAMPLE_W-1:0] sat;
	logic                       clip;
	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] smoothed_q;
	logic                       clipped_q;

	assign biased = wave_i.sum + ROUND_HALF;
	assign rnd    = biased[ACC_W-1:FRAC_SHIFT];

	always_comb begin
		if (rnd > RND_MAX) begin
			sat  = SAT_MAX;
			clip = 1'b1;
		end else if (rnd < RND_MIN) begin
			sat  = SAT_MIN;
			clip = 1'b1;
		end else begin
			sat  = rnd[SAMPLE_W-1:0];
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= wave_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wave_i.valid) begin
			smoothed_q <= sat;
			clipped_q  <= clip;
		end
	end

	assign valid    = valid_q;
	assign smoothed = smoothed_q;
	assign clipped  = clipped_q;

endmodule

`default_nettype wire

/* hw/rtl/symmetric_gaussian_fir_smoother.sv */
// An accepted input beat passes through the cell row and then the output register to its result beat.
// Throughput: one beat per cycle; the cell row and output register advance together
// and freeze only while a held result beat is stalled.
// Reset: delay-line taps and all valids clear to zero, outer coefficients to 0,
// center coefficient to 65535. Uses sgf_pkg, sgf_cell, sgf_out.
`default_nettype none

module symmetric_gaussian_fir_smoother (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sgf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sgf_pkg::COEF_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [sgf_pkg::SAMPLE_W-1:0] score_in,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [sgf_pkg::SAMPLE_W-1:0]     smoothed,
	output logic                                    clipped
);
	import sgf_pkg::*;

	coef_arr_t coef_q;
	wave_t     wave [TAPS+1];
	logic      en;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= (REG_IDX_W'(i) == CENTER_REG) ? COEF_CENTER_RST : COEF_OUTER_RST;
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			coef_q[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	assign wave[0].valid  = in_valid && en;
	assign wave[0].sample = score_in;
	assign wave[0].sum    = '0;

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		sgf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.coef   (tap_coef(k, coef_q)),
			.wave_i (wave[k]),
			.wave_o (wave[k+1])
		);
	end

	sgf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.wave_i   (wave[TAPS]),
		.valid    (out_valid),
		.smoothed (smoothed),
		.clipped  (clipped)
	);

`ifndef ASSERT_OFF
	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (smoothed == SAT_MAX || smoothed == SAT_MIN))
		else $error("clipped beat without saturated value");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !wave[TAPS].valid |=> !out_valid)
		else $error("result beat repeated");
`endif

endmodule

`default_nettype wire
